// ----- hw/rtl/jsu_pkg.sv -----
// Shared types, character codes and helpers for the JSON string unescaper.
`default_nettype none

package jsu_pkg;

   // Decoder mode: plain text, after a backslash, or waiting for hex digit 1..4
   typedef enum logic [2:0] {
      MODE_NORMAL = 3'd0,
      MODE_ESC    = 3'd1,
      MODE_HEX1   = 3'd2,
      MODE_HEX2   = 3'd3,
      MODE_HEX3   = 3'd4,
      MODE_HEX4   = 3'd5
   } mode_type;

   // Result status codes
   localparam logic [1:0] STATUS_BYTE  = 2'd0;
   localparam logic [1:0] STATUS_DONE  = 2'd1;
   localparam logic [1:0] STATUS_ERROR = 2'd2;

   // Most results one input byte can cause (three-byte UTF-8 sequence)
   localparam int unsigned GROUP_MAX = 3;

   // Input characters of interest
   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_LOWER_B   = 8'h62;
   localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
   localparam logic [7:0] CHAR_LOWER_N   = 8'h6E;
   localparam logic [7:0] CHAR_LOWER_R   = 8'h72;
   localparam logic [7:0] CHAR_LOWER_T   = 8'h74;
   localparam logic [7:0] CHAR_LOWER_U   = 8'h75;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;

   // Control bytes produced by escapes
   localparam logic [7:0] CTRL_BS  = 8'h08;
   localparam logic [7:0] CTRL_TAB = 8'h09;
   localparam logic [7:0] CTRL_LF  = 8'h0A;
   localparam logic [7:0] CTRL_FF  = 8'h0C;
   localparam logic [7:0] CTRL_CR  = 8'h0D;

   // UTF-8 lead and continuation markers
   localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
   localparam logic [7:0] UTF8_CONT  = 8'h80;

   // Results caused by one input byte, oldest in bytes[0]
   typedef struct packed {
      logic [1:0]       count;
      logic [1:0]       status;
      logic [2:0][7:0]  bytes;
   } group_type;

   // Hex digit decode: bit 4 set when the byte is a hex digit, low nibble its value
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/jsu_req_if.sv -----
// Input channel: one string byte per beat.
`default_nettype none

interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/jsu_rsp_if.sv -----
// Result channel: one decoded byte or end status per beat.
`default_nettype none

interface jsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic [1:0] status;
   logic       last;

   modport source (output valid, output out_byte, output byte_valid, output status,
                   output last, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input status,
                   input last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/json_string_unescape.sv -----
// Top level of the streaming JSON string unescaper.
// Feed the bytes of a JSON string body, starting after the opening quote, one per
// beat on req_chan. Each byte yields zero to three result beats on rsp_chan: a
// decoded byte (status 0), a close (status 1) or a syntax error (status 2), with
// last marking the final beat caused by that byte. A byte is taken every cycle
// while the results fit through the single result register; a byte that causes
// more than one result holds the input until its last result beat leaves, so a
// \uXXXX escape that becomes three UTF-8 bytes holds the input after its last hex digit.
// Backslashes, \u and the first three hex digits produce no beat. After a close
// or an error the decoder is back in plain-text mode.
`default_nettype none

module json_string_unescape (
   input  wire logic  clock,
   input  wire logic  reset,
   jsu_req_if.sink    req_chan,
   jsu_rsp_if.source  rsp_chan
);

   jsu_pkg::group_type group;
   logic               take_ok;
   logic               req_fire;

   assign req_chan.ready = take_ok;
   assign req_fire       = req_chan.valid && take_ok;

   jsu_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .in_byte (req_chan.in_byte),
      .accept  (req_fire),
      .group   (group)
   );

   jsu_serial u_serial (
      .clock    (clock),
      .reset    (reset),
      .group    (group),
      .req_fire (req_fire),
      .take_ok  (take_ok),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/jsu_decode.sv -----
// Escape decoder: mode and code point state, and the result group per input byte.
`default_nettype none

module jsu_decode (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [7:0]        in_byte,
   input  wire logic              accept,
   output jsu_pkg::group_type     group
);

   jsu_pkg::mode_type mode_ff, mode_in;
   logic [11:0]       code_accum_ff, code_accum_in;

   logic [4:0]  hex;
   logic [15:0] code_point;

   assign hex        = jsu_pkg::hex_digit(in_byte);
   assign code_point = {code_accum_ff, hex[3:0]};

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= jsu_pkg::MODE_NORMAL;
         code_accum_ff <= '0;
      end else if (accept) begin
         mode_ff       <= mode_in;
         code_accum_ff <= code_accum_in;
      end
   end

   // Next state
   always_comb begin
      mode_in       = jsu_pkg::MODE_NORMAL;
      code_accum_in = '0;
      if (in_byte != jsu_pkg::CHAR_NUL) begin
         unique case (mode_ff)
            jsu_pkg::MODE_ESC: begin
               if (in_byte == jsu_pkg::CHAR_LOWER_U) begin
                  mode_in = jsu_pkg::MODE_HEX1;
               end
            end
            jsu_pkg::MODE_HEX1: begin
               if (hex[4]) begin
                  mode_in       = jsu_pkg::MODE_HEX2;
                  code_accum_in = code_point[11:0];
               end
            end
            jsu_pkg::MODE_HEX2: begin
               if (hex[4]) begin
                  mode_in       = jsu_pkg::MODE_HEX3;
                  code_accum_in = code_point[11:0];
               end
            end
            jsu_pkg::MODE_HEX3: begin
               if (hex[4]) begin
                  mode_in       = jsu_pkg::MODE_HEX4;
                  code_accum_in = code_point[11:0];
               end
            end
            jsu_pkg::MODE_HEX4: begin
               mode_in = jsu_pkg::MODE_NORMAL;
            end
            default: begin
               if (in_byte == jsu_pkg::CHAR_BACKSLASH) begin
                  mode_in = jsu_pkg::MODE_ESC;
               end
            end
         endcase
      end
   end

   // Result group
   always_comb begin
      group        = '0;
      group.status = jsu_pkg::STATUS_BYTE;
      if (in_byte == jsu_pkg::CHAR_NUL) begin
         group.count  = 2'd1;
         group.status = jsu_pkg::STATUS_ERROR;
      end else begin
         unique case (mode_ff) inside
            jsu_pkg::MODE_ESC: begin
               group.count = 2'd1;
               unique case (in_byte)
                  jsu_pkg::CHAR_QUOTE:     group.bytes[0] = jsu_pkg::CHAR_QUOTE;
                  jsu_pkg::CHAR_BACKSLASH: group.bytes[0] = jsu_pkg::CHAR_BACKSLASH;
                  jsu_pkg::CHAR_SLASH:     group.bytes[0] = jsu_pkg::CHAR_SLASH;
                  jsu_pkg::CHAR_LOWER_B:   group.bytes[0] = jsu_pkg::CTRL_BS;
                  jsu_pkg::CHAR_LOWER_F:   group.bytes[0] = jsu_pkg::CTRL_FF;
                  jsu_pkg::CHAR_LOWER_N:   group.bytes[0] = jsu_pkg::CTRL_LF;
                  jsu_pkg::CHAR_LOWER_R:   group.bytes[0] = jsu_pkg::CTRL_CR;
                  jsu_pkg::CHAR_LOWER_T:   group.bytes[0] = jsu_pkg::CTRL_TAB;
                  jsu_pkg::CHAR_LOWER_U:   group.count    = 2'd0;
                  default:                 group.status   = jsu_pkg::STATUS_ERROR;
               endcase
            end
            jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2, jsu_pkg::MODE_HEX3,
            jsu_pkg::MODE_HEX4: begin
               if (!hex[4]) begin
                  group.count  = 2'd1;
                  group.status = jsu_pkg::STATUS_ERROR;
               end else if (mode_ff == jsu_pkg::MODE_HEX4) begin
                  // UTF-8 encode the finished code point
                  if (code_point[15:7] == '0) begin
                     group.count    = 2'd1;
                     group.bytes[0] = code_point[7:0];
                  end else if (code_point[15:11] == '0) begin
                     group.count    = 2'd2;
                     group.bytes[0] = jsu_pkg::UTF8_LEAD2 | {3'b000, code_point[10:6]};
                     group.bytes[1] = jsu_pkg::UTF8_CONT | {2'b00, code_point[5:0]};
                  end else begin
                     group.count    = 2'd3;
                     group.bytes[0] = jsu_pkg::UTF8_LEAD3 | {4'b0000, code_point[15:12]};
                     group.bytes[1] = jsu_pkg::UTF8_CONT | {2'b00, code_point[11:6]};
                     group.bytes[2] = jsu_pkg::UTF8_CONT | {2'b00, code_point[5:0]};
                  end
               end
            end
            default: begin
               if (in_byte == jsu_pkg::CHAR_QUOTE) begin
                  group.count  = 2'd1;
                  group.status = jsu_pkg::STATUS_DONE;
               end else if (in_byte < jsu_pkg::CHAR_SPACE && in_byte != jsu_pkg::CTRL_TAB) begin
                  group.count  = 2'd1;
                  group.status = jsu_pkg::STATUS_ERROR;
               end else if (in_byte != jsu_pkg::CHAR_BACKSLASH) begin
                  group.count    = 2'd1;
                  group.bytes[0] = in_byte;
               end
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/jsu_serial.sv -----
// Result register: holds one group of results and hands them out one beat at a time.
`default_nettype none

module jsu_serial (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire jsu_pkg::group_type group,
   input  wire logic               req_fire,
   output logic                    take_ok,
   jsu_rsp_if.source               rsp_chan
);

   logic [1:0]      cnt_ff, cnt_in;
   logic [1:0]      status_ff;
   logic [2:0][7:0] byte_ff;
   logic            load;
   logic            rsp_fire;

   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   assign load     = req_fire && (group.count != 2'd0);

   // Room for a new group when empty or when the final beat leaves now
   assign take_ok = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_chan.ready);

   // Pending beat count
   always_comb begin
      cnt_in = cnt_ff;
      if (load) begin
         cnt_in = group.count;
      end else if (rsp_fire) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Payload: load a group, or shift to the next byte after each beat
   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= group.status;
         byte_ff   <= group.bytes;
      end else if (rsp_fire) begin
         byte_ff <= {8'h00, byte_ff[2:1]};
      end
   end

   assign rsp_chan.valid      = (cnt_ff != 2'd0);
   assign rsp_chan.out_byte   = byte_ff[0];
   assign rsp_chan.byte_valid = (status_ff == jsu_pkg::STATUS_BYTE);
   assign rsp_chan.status     = status_ff;
   assign rsp_chan.last       = (cnt_ff == 2'd1);

endmodule

`default_nettype wire

// ----- dv/tb_json_string_unescape.sv -----
// Self-checking testbench for the JSON string unescaper: directed table, then random strings.
`default_nettype none

module tb_json_string_unescape;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          HALF_PERIOD   = 5;
   localparam int          RESET_CYCLES  = 12;
   localparam int          LONG_HOLD     = 300;
   localparam int          ITEMS_PER_RUN = 45;
   localparam int          DRAIN_CYCLES  = 10;
   localparam int          MAX_PRINTS    = 30;
   localparam longint      TIMEOUT_NS    = 5_000_000;

   // ASCII ranges used by hex digits
   localparam logic [7:0]  ASCII_0       = 8'h30;
   localparam logic [7:0]  ASCII_9       = 8'h39;
   localparam logic [7:0]  ASCII_UPPER_A = 8'h41;
   localparam logic [7:0]  ASCII_UPPER_F = 8'h46;
   localparam logic [7:0]  ASCII_LOWER_A = 8'h61;
   localparam logic [7:0]  ASCII_LOWER_F = 8'h66;
   localparam logic [7:0]  ASCII_LOWER_G = 8'h67;
   localparam logic [7:0]  ASCII_LOWER_X = 8'h78;
   localparam logic [7:0]  ASCII_1       = 8'h31;
   localparam logic [7:0]  ASCII_7       = 8'h37;
   localparam logic [7:0]  CTRL_US       = 8'h1F;

   // Code point limits for 1- and 2-byte UTF-8
   localparam logic [15:0] CP_ONE_BYTE_MAX = 16'h007F;
   localparam logic [15:0] CP_TWO_BYTE_MAX = 16'h07FF;

   // How a directed row is checked
   typedef enum logic [1:0] {
      CHK_PREDICT = 2'd0,
      CHK_BYTE    = 2'd1,
      CHK_DONE    = 2'd2,
      CHK_ERROR   = 2'd3
   } check_kind_type;

   typedef struct packed {
      logic [7:0]     in_byte;
      check_kind_type kind;
      logic [7:0]     want;
   } directed_row_type;

   typedef struct packed {
      logic [7:0] data;
      logic       data_valid;
      logic [1:0] status;
      logic       last;
   } decoded_beat_type;

   logic clock;
   logic reset;

   jsu_req_if req_chan ();
   jsu_rsp_if rsp_chan ();

   json_string_unescape dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Decoder state mirrored by the predictor
   jsu_pkg::mode_type dec_mode;
   logic [15:0]       code_accum;
   decoded_beat_type  pending_beats[$];

   int              mismatch_count;
   int              bytes_sent;
   int              send_idle_pct;
   int              rsp_stall_pct;
   logic            hold_rsp;

   logic [7:0] escape_letters [8] = '{jsu_pkg::CHAR_QUOTE, jsu_pkg::CHAR_BACKSLASH,
                                      jsu_pkg::CHAR_SLASH, jsu_pkg::CHAR_LOWER_B,
                                      jsu_pkg::CHAR_LOWER_F, jsu_pkg::CHAR_LOWER_N,
                                      jsu_pkg::CHAR_LOWER_R, jsu_pkg::CHAR_LOWER_T};

   // Extremes, the \n and \u escapes, hex in both cases, and each error path
   directed_row_type directed_rows [26] = '{
      '{ASCII_UPPER_A,           CHK_BYTE,    ASCII_UPPER_A},
      '{8'hFF,                   CHK_BYTE,    8'hFF},
      '{jsu_pkg::CTRL_TAB,       CHK_BYTE,    jsu_pkg::CTRL_TAB},
      '{CTRL_US,                 CHK_ERROR,   8'h00},
      '{jsu_pkg::CHAR_BACKSLASH, CHK_PREDICT, 8'h00},
      '{jsu_pkg::CHAR_LOWER_N,   CHK_BYTE,    jsu_pkg::CTRL_LF},
      '{jsu_pkg::CHAR_BACKSLASH, CHK_PREDICT, 8'h00},
      '{jsu_pkg::CHAR_LOWER_U,   CHK_PREDICT, 8'h00},
      '{ASCII_0,                 CHK_PREDICT, 8'h00},
      '{ASCII_7,                 CHK_PREDICT, 8'h00},
      '{ASCII_UPPER_F,           CHK_PREDICT, 8'h00},
      '{ASCII_LOWER_F,           CHK_PREDICT, 8'h00},
      '{jsu_pkg::CHAR_BACKSLASH, CHK_PREDICT, 8'h00},
      '{jsu_pkg::CHAR_LOWER_U,   CHK_PREDICT, 8'h00},
      '{ASCII_UPPER_F,           CHK_PREDICT, 8'h00},
      '{ASCII_LOWER_F,           CHK_PREDICT, 8'h00},
      '{ASCII_LOWER_F,           CHK_PREDICT, 8'h00},
      '{ASCII_LOWER_F,           CHK_PREDICT, 8'h00},
      '{jsu_pkg::CHAR_BACKSLASH, CHK_PREDICT, 8'h00},
      '{ASCII_LOWER_X,           CHK_ERROR,   8'h00},
      '{jsu_pkg::CHAR_BACKSLASH, CHK_PREDICT, 8'h00},
      '{jsu_pkg::CHAR_LOWER_U,   CHK_PREDICT, 8'h00},
      '{ASCII_1,                 CHK_PREDICT, 8'h00},
      '{ASCII_LOWER_G,           CHK_ERROR,   8'h00},
      '{jsu_pkg::CHAR_NUL,       CHK_ERROR,   8'h00},
      '{jsu_pkg::CHAR_QUOTE,     CHK_DONE,    8'h00}
   };

   // Clock
   initial clock = 1'b0;
   always #(HALF_PERIOD) clock = ~clock;

   // Watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("[json_string_unescape] ERROR");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_PRINTS) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
      mismatch_count++;
   endtask

   function automatic int hex_nibble(input logic [7:0] c);
      if (c >= ASCII_0 && c <= ASCII_9) return int'(c - ASCII_0);
      if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_F) return int'(c - ASCII_UPPER_A) + 10;
      if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_F) return int'(c - ASCII_LOWER_A) + 10;
      return -1;
   endfunction

   // Append one expected beat at the tail of the queue
   function automatic void queue_beat(input decoded_beat_type beat);
      pending_beats = {pending_beats, beat};
   endfunction

   function automatic void emit_byte(input logic [7:0] b, input logic is_last);
      queue_beat('{b, 1'b1, jsu_pkg::STATUS_BYTE, is_last});
   endfunction

   // Close or error: single status beat, decoder back to plain text
   function automatic void end_string(input logic [1:0] st);
      dec_mode   = jsu_pkg::MODE_NORMAL;
      code_accum = '0;
      queue_beat('{8'h00, 1'b0, st, 1'b1});
   endfunction

   // Expected beats for one accepted string byte
   function automatic void predict_unescape(input logic [7:0] c);
      int          nib;
      logic [15:0] cp;
      nib = hex_nibble(c);
      if (c == jsu_pkg::CHAR_NUL) begin
         end_string(jsu_pkg::STATUS_ERROR);
         return;
      end
      case (dec_mode)
         jsu_pkg::MODE_ESC: begin
            dec_mode = jsu_pkg::MODE_NORMAL;
            case (c)
               jsu_pkg::CHAR_QUOTE, jsu_pkg::CHAR_BACKSLASH,
               jsu_pkg::CHAR_SLASH:   emit_byte(c, 1'b1);
               jsu_pkg::CHAR_LOWER_B: emit_byte(jsu_pkg::CTRL_BS, 1'b1);
               jsu_pkg::CHAR_LOWER_F: emit_byte(jsu_pkg::CTRL_FF, 1'b1);
               jsu_pkg::CHAR_LOWER_N: emit_byte(jsu_pkg::CTRL_LF, 1'b1);
               jsu_pkg::CHAR_LOWER_R: emit_byte(jsu_pkg::CTRL_CR, 1'b1);
               jsu_pkg::CHAR_LOWER_T: emit_byte(jsu_pkg::CTRL_TAB, 1'b1);
               jsu_pkg::CHAR_LOWER_U: begin
                  dec_mode   = jsu_pkg::MODE_HEX1;
                  code_accum = '0;
               end
               default: end_string(jsu_pkg::STATUS_ERROR);
            endcase
         end
         jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2, jsu_pkg::MODE_HEX3,
         jsu_pkg::MODE_HEX4: begin
            if (nib < 0) begin
               end_string(jsu_pkg::STATUS_ERROR);
            end else begin
               cp = {code_accum[11:0], 4'(nib)};
               if (dec_mode != jsu_pkg::MODE_HEX4) begin
                  code_accum = cp;
                  dec_mode   = jsu_pkg::mode_type'(dec_mode + 3'd1);
               end else begin
                  dec_mode   = jsu_pkg::MODE_NORMAL;
                  code_accum = '0;
                  if (cp <= CP_ONE_BYTE_MAX) begin
                     emit_byte(cp[7:0], 1'b1);
                  end else if (cp <= CP_TWO_BYTE_MAX) begin
                     emit_byte(jsu_pkg::UTF8_LEAD2 | {3'b000, cp[10:6]}, 1'b0);
                     emit_byte(jsu_pkg::UTF8_CONT | {2'b00, cp[5:0]}, 1'b1);
                  end else begin
                     emit_byte(jsu_pkg::UTF8_LEAD3 | {4'b0000, cp[15:12]}, 1'b0);
                     emit_byte(jsu_pkg::UTF8_CONT | {2'b00, cp[11:6]}, 1'b0);
                     emit_byte(jsu_pkg::UTF8_CONT | {2'b00, cp[5:0]}, 1'b1);
                  end
               end
            end
         end
         default: begin
            // plain text
            dec_mode = jsu_pkg::MODE_NORMAL;
            if (c == jsu_pkg::CHAR_BACKSLASH) begin
               dec_mode = jsu_pkg::MODE_ESC;
            end else if (c == jsu_pkg::CHAR_QUOTE) begin
               end_string(jsu_pkg::STATUS_DONE);
            end else if (c < jsu_pkg::CHAR_SPACE && c != jsu_pkg::CTRL_TAB) begin
               end_string(jsu_pkg::STATUS_ERROR);
            end else begin
               emit_byte(c, 1'b1);
            end
         end
      endcase
   endfunction

   // Drive one byte at the falling edge, hold until accepted, then predict
   task automatic send_byte(input logic [7:0] b, input check_kind_type kind = CHK_PREDICT,
                            input logic [7:0] want = 8'h00);
      int keep;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid   = 1'b1;
      req_chan.in_byte = b;
      do @(posedge clock); while (!req_chan.ready);
      bytes_sent++;
      keep = pending_beats.size();
      predict_unescape(b);
      // typed rows: state from the predictor, expectation from the table
      if (kind != CHK_PREDICT) begin
         while (pending_beats.size() > keep) void'(pending_beats.pop_back());
         case (kind)
            CHK_BYTE: queue_beat('{want, 1'b1, jsu_pkg::STATUS_BYTE, 1'b1});
            CHK_DONE: queue_beat('{8'h00, 1'b0, jsu_pkg::STATUS_DONE, 1'b1});
            default:  queue_beat('{8'h00, 1'b0, jsu_pkg::STATUS_ERROR, 1'b1});
         endcase
      end
   endtask

   task automatic go_idle();
      @(negedge clock);
      req_chan.valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_beats.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return ASCII_0 + 8'(n);
      if ($urandom_range(1) == 0) return ASCII_LOWER_A + 8'(n - 4'd10);
      return ASCII_UPPER_A + 8'(n - 4'd10);
   endfunction

   task automatic send_unicode(input logic [15:0] cp);
      send_byte(jsu_pkg::CHAR_BACKSLASH);
      send_byte(jsu_pkg::CHAR_LOWER_U);
      send_byte(hex_char(cp[15:12]));
      send_byte(hex_char(cp[11:8]));
      send_byte(hex_char(cp[7:4]));
      send_byte(hex_char(cp[3:0]));
   endtask

   // One random fragment of a string: mostly well formed, some noise
   task automatic send_random_fragment();
      int          pick;
      int          k;
      logic [7:0]  b;
      logic [15:0] cp;
      pick = $urandom_range(99);
      if (pick < 45) begin
         b = 8'($urandom_range(255, 32));
         if (b == jsu_pkg::CHAR_BACKSLASH || b == jsu_pkg::CHAR_QUOTE) b = jsu_pkg::CTRL_TAB;
         send_byte(b);
      end else if (pick < 65) begin
         send_byte(jsu_pkg::CHAR_BACKSLASH);
         send_byte(escape_letters[$urandom_range(7)]);
      end else if (pick < 83) begin
         case ($urandom_range(2))
            0:       cp = 16'($urandom_range(32'h007F));
            1:       cp = 16'($urandom_range(32'h07FF, 32'h0080));
            default: cp = 16'($urandom_range(32'hFFFF, 32'h0800));
         endcase
         send_unicode(cp);
      end else if (pick < 88) begin
         send_byte(jsu_pkg::CHAR_QUOTE);
      end else if (pick < 94) begin
         send_byte(8'($urandom_range(255)));
      end else begin
         // broken escape: cut off at a random point by an arbitrary byte
         send_byte(jsu_pkg::CHAR_BACKSLASH);
         if ($urandom_range(1) == 1) begin
            send_byte(jsu_pkg::CHAR_LOWER_U);
            k = $urandom_range(3);
            repeat (k) send_byte(hex_char(4'($urandom_range(15))));
         end
         send_byte(8'($urandom_range(255)));
      end
   endtask

   // Receiver: random stalls plus an optional long hold-off
   always @(negedge clock) begin
      rsp_chan.ready <= !hold_rsp && ($urandom_range(99) >= rsp_stall_pct);
   end

   // Compare each accepted result beat with the oldest expectation
   always @(posedge clock) begin : result_check
      decoded_beat_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_beats.size() == 0) begin
            report_mismatch($sformatf("unexpected beat byte=%h status=%0d",
                                      rsp_chan.out_byte, rsp_chan.status));
         end else begin
            want = pending_beats.pop_front();
            if (rsp_chan.out_byte !== want.data)
               report_mismatch($sformatf("out_byte %h, want %h", rsp_chan.out_byte, want.data));
            if (rsp_chan.byte_valid !== want.data_valid)
               report_mismatch($sformatf("byte_valid %b, want %b",
                                         rsp_chan.byte_valid, want.data_valid));
            if (rsp_chan.status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d", rsp_chan.status, want.status));
            if (rsp_chan.last !== want.last)
               report_mismatch($sformatf("last %b, want %b", rsp_chan.last, want.last));
         end
      end
   end

   // Main sequence
   initial begin
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.in_byte = 8'h00;
      hold_rsp         = 1'b0;
      send_idle_pct    = 0;
      rsp_stall_pct    = 0;
      mismatch_count   = 0;
      bytes_sent       = 0;
      dec_mode         = jsu_pkg::MODE_NORMAL;
      code_accum       = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      foreach (directed_rows[i]) begin
         send_byte(directed_rows[i].in_byte, directed_rows[i].kind, directed_rows[i].want);
      end
      go_idle();
      wait_drained();

      // random phases: free flow (with one long hold-off), slow sender, slow receiver, both
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 85; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 85; end
            default: begin send_idle_pct = 16; rsp_stall_pct = 16; end
         endcase
         if (phase == 0) begin
            fork
               begin
                  hold_rsp <= 1'b1;
                  repeat (LONG_HOLD) @(negedge clock);
                  hold_rsp <= 1'b0;
               end
            join_none
         end
         begin : phase_items
            int stop_at;
            stop_at = bytes_sent + ITEMS_PER_RUN;
            while (bytes_sent < stop_at) send_random_fragment();
         end
         // sender pauses until every expected beat is back
         go_idle();
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_beats.size() == 0) begin
         $display("[json_string_unescape] OK");
      end else begin
         $display("[json_string_unescape] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
